// ----- hw/rtl/apvt_pkg.sv -----
// Shared types and constants for the affine point/vector transform.
package apvt_pkg;

    // Field widths
    localparam int COL_W     = 48;
    localparam int COMP_W    = 16;
    localparam int COORD_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_SH   = 12;

    // Datapath widths: 16x32 product, sum of three, shifted, plus offset
    localparam int PROD_W = COMP_W + COORD_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SHR_W  = SUM_W - FRAC_SH;
    localparam int TOT_W  = SHR_W + 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFS_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFS_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFS_Z = 3'd5;

    // Reset values: identity matrix (1.0 in Q3.12 on the diagonal)
    localparam logic [COL_W-1:0] RIGHT_RST = 48'h0000_0000_1000;
    localparam logic [COL_W-1:0] UP_RST    = 48'h0000_1000_0000;
    localparam logic [COL_W-1:0] AT_RST    = 48'h1000_0000_0000;

    // Saturation limits
    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

    // Per-stage load enables handed to the lanes
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_pipe_ctl;

endpackage

// ----- hw/rtl/apvt_lane.sv -----
// One output row: three products, floor shift, translation and saturation.
module apvt_lane (
    input  logic                                  i_clk,
    input  apvt_pkg::t_pipe_ctl                   i_ctl,
    input  logic signed [apvt_pkg::COMP_W-1:0]    i_cr,
    input  logic signed [apvt_pkg::COMP_W-1:0]    i_cu,
    input  logic signed [apvt_pkg::COMP_W-1:0]    i_ca,
    input  logic signed [apvt_pkg::COORD_W-1:0]   i_ofs,
    input  logic                                  i_point,
    input  logic signed [apvt_pkg::COORD_W-1:0]   i_x,
    input  logic signed [apvt_pkg::COORD_W-1:0]   i_y,
    input  logic signed [apvt_pkg::COORD_W-1:0]   i_z,
    output logic signed [apvt_pkg::COORD_W-1:0]   o_res,
    output logic                                  o_clip
);

    logic signed [apvt_pkg::PROD_W-1:0]  r_px, r_py, r_pz;
    logic signed [apvt_pkg::SUM_W-1:0]   n_sum;
    logic signed [apvt_pkg::SHR_W-1:0]   r_sh;
    logic signed [apvt_pkg::TOT_W-1:0]   n_tot;
    logic signed [apvt_pkg::TOT_W-1:0]   n_ofs;
    logic                                n_fits;
    logic signed [apvt_pkg::COORD_W-1:0] n_res;

    // Stage 1: exact products
    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_px <= i_cr * i_x;
            r_py <= i_cu * i_y;
            r_pz <= i_ca * i_z;
        end
    end

    // Stage 2: sum and arithmetic shift (floor)
    assign n_sum = apvt_pkg::SUM_W'(r_px) + apvt_pkg::SUM_W'(r_py) + apvt_pkg::SUM_W'(r_pz);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_sh <= apvt_pkg::SHR_W'(n_sum >>> apvt_pkg::FRAC_SH);
        end
    end

    // Stage 3: translation, then clamp to 32 bits
    assign n_ofs  = i_point ? apvt_pkg::TOT_W'(i_ofs) : '0;
    assign n_tot  = apvt_pkg::TOT_W'(r_sh) + n_ofs;
    // fits when all bits above the sign bit of the 32-bit result agree with it
    assign n_fits = (n_tot[apvt_pkg::TOT_W-1:apvt_pkg::COORD_W-1] == '0) ||
                    (n_tot[apvt_pkg::TOT_W-1:apvt_pkg::COORD_W-1] == '1);
    assign n_res  = n_fits ? n_tot[apvt_pkg::COORD_W-1:0] :
                    (n_tot[apvt_pkg::TOT_W-1] ? apvt_pkg::COORD_MIN : apvt_pkg::COORD_MAX);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            o_res  <= n_res;
            o_clip <= !n_fits;
        end
    end

endmodule

// ----- hw/rtl/apvt_merge.sv -----
// Output word register: gathers the three lanes and ORs their clip flags.
module apvt_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [apvt_pkg::COORD_W-1:0] i_res_x,
    input  logic signed [apvt_pkg::COORD_W-1:0] i_res_y,
    input  logic signed [apvt_pkg::COORD_W-1:0] i_res_z,
    input  logic [2:0]                          i_clip,
    input  logic                                i_batch_end,
    input  logic                                i_out_stall,
    output logic                                o_load,
    output logic                                o_out_valid,
    output logic signed [apvt_pkg::COORD_W-1:0] o_out_x,
    output logic signed [apvt_pkg::COORD_W-1:0] o_out_y,
    output logic signed [apvt_pkg::COORD_W-1:0] o_out_z,
    output logic                                o_clipped,
    output logic                                o_batch_last
);

    logic r_valid;

    // Register is free when empty or being drained this cycle
    assign o_load      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            o_out_x      <= i_res_x;
            o_out_y      <= i_res_y;
            o_out_z      <= i_res_z;
            o_clipped    <= |i_clip;
            o_batch_last <= i_batch_end;
        end
    end

endmodule

// ----- hw/rtl/affine_point_vector_transform.sv -----
// Affine point/vector transform: three row lanes and an output register.
// Throughput: one word per cycle while the output is not stalled; each row lane
// is a three-stage multiply/sum/saturate pipeline followed by the output register.
// Reset (synchronous, active low) empties the pipeline and loads the identity
// matrix with zero translation.
module affine_point_vector_transform (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [apvt_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [apvt_pkg::COL_W-1:0]            i_cfg_data,
    // input words
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_mode,
    input  logic signed [apvt_pkg::COORD_W-1:0]   i_in_x,
    input  logic signed [apvt_pkg::COORD_W-1:0]   i_in_y,
    input  logic signed [apvt_pkg::COORD_W-1:0]   i_in_z,
    input  logic                                  i_batch_end,
    // result words
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [apvt_pkg::COORD_W-1:0]   o_out_x,
    output logic signed [apvt_pkg::COORD_W-1:0]   o_out_y,
    output logic signed [apvt_pkg::COORD_W-1:0]   o_out_z,
    output logic                                  o_clipped,
    output logic                                  o_batch_last
);

    logic [apvt_pkg::COL_W-1:0]   r_right, r_up, r_at;
    logic [apvt_pkg::COORD_W-1:0] r_ofs_x, r_ofs_y, r_ofs_z;

    logic r_v1, r_v2, r_v3;
    logic r_pt1, r_pt2;
    logic r_be1, r_be2, r_be3;
    logic n_load_out;
    apvt_pkg::t_pipe_ctl n_ctl;

    logic signed [apvt_pkg::COORD_W-1:0] n_res_x, n_res_y, n_res_z;
    logic [2:0] n_clip;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right <= apvt_pkg::RIGHT_RST;
            r_up    <= apvt_pkg::UP_RST;
            r_at    <= apvt_pkg::AT_RST;
            r_ofs_x <= '0;
            r_ofs_y <= '0;
            r_ofs_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                apvt_pkg::REG_RIGHT: r_right <= i_cfg_data;
                apvt_pkg::REG_UP:    r_up    <= i_cfg_data;
                apvt_pkg::REG_AT:    r_at    <= i_cfg_data;
                apvt_pkg::REG_OFS_X: r_ofs_x <= i_cfg_data[apvt_pkg::COORD_W-1:0];
                apvt_pkg::REG_OFS_Y: r_ofs_y <= i_cfg_data[apvt_pkg::COORD_W-1:0];
                apvt_pkg::REG_OFS_Z: r_ofs_z <= i_cfg_data[apvt_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when empty or when the next one loads
    assign n_ctl.en3  = !r_v3 || n_load_out;
    assign n_ctl.en2  = !r_v2 || n_ctl.en3;
    assign n_ctl.en1  = !r_v1 || n_ctl.en2;
    assign o_in_stall = !n_ctl.en1;

    // Valid and sideband pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (n_ctl.en1) r_v1 <= i_in_valid;
            if (n_ctl.en2) r_v2 <= r_v1;
            if (n_ctl.en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_ctl.en1) begin
            r_pt1 <= !i_mode;
            r_be1 <= i_batch_end;
        end
        if (n_ctl.en2) begin
            r_pt2 <= r_pt1;
            r_be2 <= r_be1;
        end
        if (n_ctl.en3) begin
            r_be3 <= r_be2;
        end
    end

    // Row lanes: lane k uses component k of every column
    apvt_lane u_lane_x (
        .i_clk   (i_clk),
        .i_ctl   (n_ctl),
        .i_cr    (r_right[15:0]),
        .i_cu    (r_up[15:0]),
        .i_ca    (r_at[15:0]),
        .i_ofs   (r_ofs_x),
        .i_point (r_pt2),
        .i_x     (i_in_x),
        .i_y     (i_in_y),
        .i_z     (i_in_z),
        .o_res   (n_res_x),
        .o_clip  (n_clip[0])
    );

    apvt_lane u_lane_y (
        .i_clk   (i_clk),
        .i_ctl   (n_ctl),
        .i_cr    (r_right[31:16]),
        .i_cu    (r_up[31:16]),
        .i_ca    (r_at[31:16]),
        .i_ofs   (r_ofs_y),
        .i_point (r_pt2),
        .i_x     (i_in_x),
        .i_y     (i_in_y),
        .i_z     (i_in_z),
        .o_res   (n_res_y),
        .o_clip  (n_clip[1])
    );

    apvt_lane u_lane_z (
        .i_clk   (i_clk),
        .i_ctl   (n_ctl),
        .i_cr    (r_right[47:32]),
        .i_cu    (r_up[47:32]),
        .i_ca    (r_at[47:32]),
        .i_ofs   (r_ofs_z),
        .i_point (r_pt2),
        .i_x     (i_in_x),
        .i_y     (i_in_y),
        .i_z     (i_in_z),
        .o_res   (n_res_z),
        .o_clip  (n_clip[2])
    );

    // Output word
    apvt_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_v3),
        .i_res_x      (n_res_x),
        .i_res_y      (n_res_y),
        .i_res_z      (n_res_z),
        .i_clip       (n_clip),
        .i_batch_end  (r_be3),
        .i_out_stall  (i_out_stall),
        .o_load       (n_load_out),
        .o_out_valid  (o_out_valid),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .o_clipped    (o_clipped),
        .o_batch_last (o_batch_last)
    );

    // Input backs up only when every stage holds a word and the output is stalled
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && o_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

    // An accepted word lands in the first stage
    a_accept_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v1)
        else $error("accepted word lost at stage 1");

    // A finished row with a free output register reaches the output next cycle
    a_s3_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && n_load_out) |=> o_out_valid)
        else $error("stage 3 word dropped");

    // A clipped word carries at least one limit value
    a_clip_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |->
            (o_out_x == apvt_pkg::COORD_MAX || o_out_x == apvt_pkg::COORD_MIN ||
             o_out_y == apvt_pkg::COORD_MAX || o_out_y == apvt_pkg::COORD_MIN ||
             o_out_z == apvt_pkg::COORD_MAX || o_out_z == apvt_pkg::COORD_MIN))
        else $error("clip flag without a saturated component");

endmodule

// ----- tb/tb_affine_point_vector_transform.sv -----
// Self-checking testbench for the affine point/vector transform.
module tb_affine_point_vector_transform;
    timeunit 1ns;
    timeprecision 1ps;

    import apvt_pkg::*;

    localparam int IDLE_LIMIT    = 3000;
    localparam int PHASES        = 8;
    localparam int WORDS_PER_PHASE = 50;
    localparam int MAX_REPORTS   = 10;

    localparam int CMAX = COORD_MAX;
    localparam int CMIN = COORD_MIN;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    // Indexes past the last register; writes to them are dropped
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_7 = 3'd7;

    typedef enum logic {
        MODE_POINT = 1'b0,
        MODE_DIR   = 1'b1
    } mode_e;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      clipped;
        logic                      batch_last;
    } result_t;

    // One row of the directed table: a register write or a word to send
    typedef struct packed {
        logic                      is_cfg;
        logic [CFG_IDX_W-1:0]      idx;
        logic [COL_W-1:0]          data;
        logic                      mode;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      be;
        logic                      typed;
        result_t                   want;
    } step_t;

    // DUT inputs, all known from time zero
    logic                       i_clk;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx   = '0;
    logic [COL_W-1:0]           i_cfg_data  = '0;
    logic                       i_in_valid  = 1'b0;
    logic                       i_mode      = 1'b0;
    logic signed [COORD_W-1:0]  i_in_x      = '0;
    logic signed [COORD_W-1:0]  i_in_y      = '0;
    logic signed [COORD_W-1:0]  i_in_z      = '0;
    logic                       i_batch_end = 1'b0;
    logic                       i_out_stall = 1'b0;

    logic                       o_in_stall;
    logic                       o_out_valid;
    logic signed [COORD_W-1:0]  o_out_x;
    logic signed [COORD_W-1:0]  o_out_y;
    logic signed [COORD_W-1:0]  o_out_z;
    logic                       o_clipped;
    logic                       o_batch_last;

    // Shadow of the transform registers
    logic [COL_W-1:0]   xform_cols [3];
    logic [COORD_W-1:0] xform_ofs  [3];

    result_t pending_results [$];
    step_t   directed_steps  [$];
    int      mismatch_count = 0;
    bit      no_idle        = 1'b0;
    int      stall_left     = 0;

    affine_point_vector_transform uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_in_x       (i_in_x),
        .i_in_y       (i_in_y),
        .i_in_z       (i_in_z),
        .i_batch_end  (i_batch_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .o_clipped    (o_clipped),
        .o_batch_last (o_batch_last)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Expected transform of one word under the current register shadow
    function automatic result_t transform_point(logic mode, logic signed [COORD_W-1:0] x,
                                                logic signed [COORD_W-1:0] y,
                                                logic signed [COORD_W-1:0] z, logic be);
        result_t res;
        logic signed [COMP_W-1:0]  cr, cu, ca;
        logic signed [COORD_W-1:0] lane [3];
        longint acc;
        logic clip;
        clip = 1'b0;
        for (int k = 0; k < 3; k++) begin
            cr  = xform_cols[0][COMP_W*k +: COMP_W];
            cu  = xform_cols[1][COMP_W*k +: COMP_W];
            ca  = xform_cols[2][COMP_W*k +: COMP_W];
            acc = longint'(cr) * longint'(x) + longint'(cu) * longint'(y) +
                  longint'(ca) * longint'(z);
            // arithmetic shift gives floor
            acc = acc >>> FRAC_SH;
            if (mode == MODE_POINT)
                acc = acc + longint'($signed(xform_ofs[k]));
            if (acc > SAT_HI) begin
                acc  = SAT_HI;
                clip = 1'b1;
            end else if (acc < SAT_LO) begin
                acc  = SAT_LO;
                clip = 1'b1;
            end
            lane[k] = acc[COORD_W-1:0];
        end
        res.out_x      = lane[0];
        res.out_y      = lane[1];
        res.out_z      = lane[2];
        res.clipped    = clip;
        res.batch_last = be;
        return res;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [COL_W-1:0] rand48();
        logic [COL_W-1:0] r;
        r[31:0]  = $urandom;
        r[47:32] = $urandom;
        return r;
    endfunction

    // Matrix column: full-range components or components in [-1.0, 1.0)
    function automatic logic [COL_W-1:0] rand_col(bit full);
        logic [COL_W-1:0] c;
        int v;
        for (int k = 0; k < 3; k++) begin
            v = full ? $urandom : $urandom_range(0, 8191) - 4096;
            c[COMP_W*k +: COMP_W] = v[COMP_W-1:0];
        end
        return c;
    endfunction

    // Coordinates: mostly moderate so results stay in range, some full range
    function automatic int rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return $urandom_range(0, 2097151) - 1048576;
        if (r < 90)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return CMAX;
            1:       return CMIN;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    function automatic step_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [COL_W-1:0] data);
        step_t s;
        s        = '0;
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.data   = data;
        return s;
    endfunction

    function automatic step_t pt_row(mode_e m, int x, int y, int z, bit be, bit typed,
                                     int ex, int ey, int ez, bit ec);
        step_t s;
        s       = '0;
        s.mode  = m;
        s.x     = x;
        s.y     = y;
        s.z     = z;
        s.be    = be;
        s.typed = typed;
        s.want  = '{ex, ey, ez, ec, be};
        return s;
    endfunction

    // Register write; called and returns at a falling edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COL_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_RIGHT: xform_cols[0] = data;
            REG_UP:    xform_cols[1] = data;
            REG_AT:    xform_cols[2] = data;
            REG_OFS_X: xform_ofs[0]  = data[COORD_W-1:0];
            REG_OFS_Y: xform_ofs[1]  = data[COORD_W-1:0];
            REG_OFS_Z: xform_ofs[2]  = data[COORD_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Hand one word to the block; valid stays high on return
    task automatic send_point(logic mode, logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
                              logic be, logic typed, result_t typed_want);
        int gap;
        gap = no_idle ? 0 : rand_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_in_x      <= x;
        i_in_y      <= y;
        i_in_z      <= z;
        i_batch_end <= be;
        do
            @(posedge i_clk);
        while (o_in_stall);
        pending_results.push_back(typed ? typed_want : transform_point(mode, x, y, z, be));
        @(negedge i_clk);
    endtask

    // Stop sending and let every result drain before touching registers
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Output stall bursts
    always @(negedge i_clk) begin
        if (no_idle) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left == 0) begin
            stall_left = ($urandom_range(0, 99) < 92) ? $urandom_range(1, 3)
                                                      : $urandom_range(8, 40);
            i_out_stall <= ($urandom_range(0, 2) == 0);
        end else begin
            stall_left = stall_left - 1;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        result_t got;
        result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_out_x, o_out_y, o_out_z, o_clipped, o_batch_last};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result word x=%0d y=%0d z=%0d clip=%0b last=%0b",
                             got.out_x, got.out_y, got.out_z, got.clipped, got.batch_last);
            end else begin
                want = pending_results.pop_front();
                if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
                    got.out_z !== want.out_z || got.clipped !== want.clipped ||
                    got.batch_last !== want.batch_last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: exp x=%0d y=%0d z=%0d clip=%0b last=%0b",
                                 want.out_x, want.out_y, want.out_z, want.clipped,
                                 want.batch_last,
                                 " | got x=%0d y=%0d z=%0d clip=%0b last=%0b",
                                 got.out_x, got.out_y, got.out_z,
                                 got.clipped, got.batch_last);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted word
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("affine_point_vector_transform regression: fail");
        $finish;
    end

    // Stimulus
    initial begin
        step_t s;
        int kind;
        bit hi_end;
        logic [COL_W-1:0] ofs_data;

        xform_cols[0] = RIGHT_RST;
        xform_cols[1] = UP_RST;
        xform_cols[2] = AT_RST;
        xform_ofs[0]  = '0;
        xform_ofs[1]  = '0;
        xform_ofs[2]  = '0;

        // Identity after reset: words pass through
        directed_steps.push_back(pt_row(MODE_POINT, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        directed_steps.push_back(pt_row(MODE_POINT, CMAX, CMIN, 1, 1, 1, CMAX, CMIN, 1, 0));
        directed_steps.push_back(pt_row(MODE_DIR, CMIN, CMAX, -1, 0, 1, CMIN, CMAX, -1, 0));
        directed_steps.push_back(pt_row(MODE_POINT, -1, -2, -3, 1, 1, -1, -2, -3, 0));
        // Extreme offsets; high data bits on an offset and spare indexes are dropped
        directed_steps.push_back(cfg_row(REG_OFS_X, 48'h0000_7FFF_FFFF));
        directed_steps.push_back(cfg_row(REG_OFS_Y, 48'hFFFF_8000_0000));
        directed_steps.push_back(cfg_row(REG_OFS_Z, 48'hABCD_0000_0001));
        directed_steps.push_back(cfg_row(IDX_SPARE_6, 48'hFFFF_FFFF_FFFF));
        directed_steps.push_back(cfg_row(IDX_SPARE_7, 48'hFFFF_FFFF_FFFF));
        // Offset overflow saturates in point mode only
        directed_steps.push_back(pt_row(MODE_POINT, 1, -1, CMAX, 0, 1, CMAX, CMIN, CMAX, 1));
        directed_steps.push_back(pt_row(MODE_DIR, 1, -1, CMAX, 1, 1, 1, -1, CMAX, 0));
        directed_steps.push_back(pt_row(MODE_POINT, 0, 0, 0, 0, 1, CMAX, CMIN, 1, 0));
        // Most negative components on one column, product overflow
        directed_steps.push_back(cfg_row(REG_RIGHT, 48'h8000_8000_8000));
        directed_steps.push_back(cfg_row(REG_UP, 48'h0));
        directed_steps.push_back(cfg_row(REG_AT, 48'h0));
        directed_steps.push_back(cfg_row(REG_OFS_X, 48'h0));
        directed_steps.push_back(cfg_row(REG_OFS_Y, 48'h0));
        directed_steps.push_back(cfg_row(REG_OFS_Z, 48'h0));
        directed_steps.push_back(pt_row(MODE_DIR, CMIN, 5, -7, 0, 1, CMAX, CMAX, CMAX, 1));
        directed_steps.push_back(pt_row(MODE_POINT, CMAX, 0, 0, 1, 1, CMIN, CMIN, CMIN, 1));
        directed_steps.push_back(pt_row(MODE_POINT, 1, 0, 0, 0, 1, -8, -8, -8, 0));
        // Smallest component: floor on the shift
        directed_steps.push_back(cfg_row(REG_RIGHT, 48'h0001_0001_0001));
        directed_steps.push_back(pt_row(MODE_POINT, -1, 0, 0, 0, 1, -1, -1, -1, 0));
        directed_steps.push_back(pt_row(MODE_POINT, 4095, 0, 0, 0, 1, 0, 0, 0, 0));
        directed_steps.push_back(pt_row(MODE_POINT, -4097, 0, 0, 0, 1, -2, -2, -2, 0));
        directed_steps.push_back(pt_row(MODE_DIR, 4096, 0, 0, 1, 1, 1, 1, 1, 0));
        // Largest components everywhere
        directed_steps.push_back(cfg_row(REG_RIGHT, 48'h7FFF_7FFF_7FFF));
        directed_steps.push_back(cfg_row(REG_UP, 48'h7FFF_7FFF_7FFF));
        directed_steps.push_back(cfg_row(REG_AT, 48'h7FFF_7FFF_7FFF));
        directed_steps.push_back(cfg_row(REG_OFS_X, 48'h0000_7FFF_FFFF));
        directed_steps.push_back(cfg_row(REG_OFS_Y, 48'h0000_8000_0000));
        directed_steps.push_back(cfg_row(REG_OFS_Z, 48'h0000_8000_0001));
        directed_steps.push_back(pt_row(MODE_POINT, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0, 0));
        directed_steps.push_back(pt_row(MODE_DIR, CMIN, CMIN, CMIN, 1, 0, 0, 0, 0, 0));
        directed_steps.push_back(pt_row(MODE_POINT, CMIN, CMAX, 0, 0, 0, 0, 0, 0, 0));
        // Mixed-sign matrix
        directed_steps.push_back(cfg_row(REG_RIGHT, 48'h1234_F00D_8001));
        directed_steps.push_back(cfg_row(REG_UP, 48'hC000_0800_FFFF));
        directed_steps.push_back(pt_row(MODE_POINT, 32'h0001_8000, -32'sd99999, 77, 1,
                                        0, 0, 0, 0, 0));
        directed_steps.push_back(pt_row(MODE_DIR, -32'sd123456, 32'h0F0F_0F0F, CMIN, 0,
                                        0, 0, 0, 0, 0));

        // Hold reset, then release it at a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table
        foreach (directed_steps[i]) begin
            s = directed_steps[i];
            if (s.is_cfg) begin
                drain_results();
                write_reg(s.idx, s.data);
            end else begin
                send_point(s.mode, s.x, s.y, s.z, s.be, s.typed, s.want);
            end
        end

        // Random phases, each with its own register setting
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            kind    = p % 4;
            hi_end  = (p < 4);
            no_idle = (p == 2 || p == 5);
            case (kind)
                0: begin
                    write_reg(REG_RIGHT, rand_col(1'b0));
                    write_reg(REG_UP, rand_col(1'b0));
                    write_reg(REG_AT, rand_col(1'b0));
                end
                1: begin
                    write_reg(REG_RIGHT, hi_end ? 48'h7FFF_7FFF_7FFF : 48'h8000_8000_8000);
                    write_reg(REG_UP, hi_end ? 48'h8000_8000_8000 : 48'h7FFF_7FFF_7FFF);
                    write_reg(REG_AT, hi_end ? 48'h7FFF_7FFF_7FFF : 48'h8000_8000_8000);
                end
                default: begin
                    write_reg(REG_RIGHT, rand_col(kind == 2));
                    write_reg(REG_UP, rand_col(kind == 2));
                    write_reg(REG_AT, rand_col(kind == 2));
                end
            endcase
            // Offsets carry random junk in the unused high bits
            for (int k = 0; k < 3; k++) begin
                ofs_data = rand48();
                if (kind == 0)
                    ofs_data[31:0] = $urandom_range(0, 16777215) - 8388608;
                else if (kind == 1)
                    ofs_data[31:0] = (hi_end ^ k[0]) ? CMAX : CMIN;
                case (k)
                    0:       write_reg(REG_OFS_X, ofs_data);
                    1:       write_reg(REG_OFS_Y, ofs_data);
                    default: write_reg(REG_OFS_Z, ofs_data);
                endcase
            end
            if ($urandom_range(0, 1))
                write_reg($urandom_range(0, 1) ? IDX_SPARE_6 : IDX_SPARE_7, rand48());

            for (int n = 0; n < WORDS_PER_PHASE; n++)
                send_point($urandom_range(0, 1), rand_coord(), rand_coord(), rand_coord(),
                           ($urandom_range(0, 3) == 0), 1'b0, '0);
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("affine_point_vector_transform regression: pass");
        else
            $display("affine_point_vector_transform regression: fail");
        $finish;
    end

endmodule
